FILE: design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector unit
// Item layouts, opcode codes, lane hand-off types and matrix reset values.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned NUM_ELEMS = 4;
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned PROD_W    = 2 * ELEM_W;
    localparam int unsigned PAIR_W    = PROD_W + 1;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned ADDSUB_W  = ELEM_W + 1;

    typedef enum logic [1:0] {
        OP_XFORM = 2'd0,
        OP_ADD   = 2'd1,
        OP_SUB   = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [1:0]               col_index;
        logic signed [ELEM_W-1:0] elem_x;
        logic signed [ELEM_W-1:0] elem_y;
        logic signed [ELEM_W-1:0] elem_z;
        logic signed [ELEM_W-1:0] elem_w;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] res_x;
        logic signed [ELEM_W-1:0] res_y;
        logic signed [ELEM_W-1:0] res_z;
        logic signed [ELEM_W-1:0] res_w;
        logic                     clamped;
    } t_out_item;

    // Control that travels alongside the lane pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
    } t_ctl;

    // One lane's finished row element
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              clamp;
    } t_lane_res;

    typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] t_row;

    // Identity matrix in Q16.16, two rows of one column per word
    localparam logic [CFG_W-1:0] MAT_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

endpackage

FILE: design/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane: one matrix row
// Four products, pair sums, final sum with floor shift, column add/subtract
// and saturation for a single result element.
// ----------------------------------------------------------------------------
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int unsigned ROW        = 0,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  t_row      i_row,    // M[ROW][0..3]
    input  t_in_item  i_item,   // item in the input stage
    input  t_ctl      i_ctl,    // control of the item in the last stage
    output t_lane_res o_res
);

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    t_row                        w_vec;
    logic signed [ELEM_W-1:0]    w_col_entry;
    logic signed [ELEM_W-1:0]    w_own_elem;

    logic signed [PROD_W-1:0]    r_prod [NUM_ELEMS];
    logic signed [ADDSUB_W-1:0]  r_addsub;
    logic signed [PAIR_W-1:0]    r_pair [2];
    logic signed [ADDSUB_W-1:0]  r_addsub_b;

    logic signed [SUM_W-1:0]     w_sum;
    logic signed [SUM_W-1:0]     w_shift;
    logic signed [SUM_W-1:0]     w_raw;
    logic signed [SUM_W-1:0]     w_sat;
    logic                        w_clamp;

    assign w_vec       = {i_item.elem_w, i_item.elem_z, i_item.elem_y, i_item.elem_x};
    assign w_col_entry = $signed(i_row[i_item.col_index]);
    assign w_own_elem  = $signed(w_vec[ROW[1:0]]);

    // Stage A: products and the column add/subtract
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_ELEMS; c++) begin
            r_prod[c] <= $signed(i_row[c]) * $signed(w_vec[c]);
        end
        if (i_item.opcode == OP_SUB) begin
            r_addsub <= ADDSUB_W'(w_col_entry) - ADDSUB_W'(w_own_elem);
        end else begin
            r_addsub <= ADDSUB_W'(w_col_entry) + ADDSUB_W'(w_own_elem);
        end
    end

    // Stage B: pair sums
    always_ff @(posedge i_clk) begin
        r_pair[0]  <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
        r_pair[1]  <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
        r_addsub_b <= r_addsub;
    end

    assign w_sum   = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
    assign w_shift = w_sum >>> FRAC_BITS;

    always_comb begin
        case (i_ctl.opcode)
            OP_XFORM: w_raw = w_shift;
            OP_ADD:   w_raw = SUM_W'(r_addsub_b);
            OP_SUB:   w_raw = SUM_W'(r_addsub_b);
            default:  w_raw = '0;
        endcase
    end

    always_comb begin
        w_clamp = 1'b0;
        w_sat   = w_raw;
        if (w_raw > SAT_MAX) begin
            w_clamp = 1'b1;
            w_sat   = SAT_MAX;
        end else if (w_raw < SAT_MIN) begin
            w_clamp = 1'b1;
            w_sat   = SAT_MIN;
        end
    end

    assign o_res.value = w_sat[ELEM_W-1:0];
    assign o_res.clamp = w_clamp;

endmodule

FILE: design/mvt_merge.sv
// ----------------------------------------------------------------------------
// mvt_merge: result register
// Gathers the four lane elements into one result item and ORs the clamp flags.
// ----------------------------------------------------------------------------
module mvt_merge
    import mvt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    input  t_lane_res i_lane [NUM_ELEMS],
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item.res_x   = $signed(i_lane[0].value);
        n_item.res_y   = $signed(i_lane[1].value);
        n_item.res_z   = $signed(i_lane[2].value);
        n_item.res_w   = $signed(i_lane[3].value);
        n_item.clamped = i_lane[0].clamp | i_lane[1].clamp
                       | i_lane[2].clamp | i_lane[3].clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/mat4_vector_transform_unit_top.sv
// ----------------------------------------------------------------------------
// mat4_vector_transform_unit_top: 4x4 signed fixed-point matrix-vector unit
// Matrix held in eight 64-bit registers; four row lanes and a result register.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle (busy is never raised) and
// delivers each result on o_res with o_res_valid once it has passed the lane
// pipeline; results appear in input order and are shown for one cycle only,
// so the receiver must take each one as it comes. The lane pipeline has one
// stage for the 32x32 products, one for the pair sums, and one for the final
// sum, floor shift, saturation and the result register.
// Matrix writes take effect at once and must only be made while no item is in
// flight.
module mat4_vector_transform_unit_top
    import mvt_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_res_valid,
    output t_out_item            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_cfg [NUM_CFG];
    t_row             w_row [NUM_ELEMS];

    t_in_item         r_item_s0;
    logic             r_vld_s0;
    t_ctl             r_ctl_a;
    t_ctl             r_ctl_b;
    t_lane_res        w_lane [NUM_ELEMS];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= MAT_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Spread the column-major register words into per-row entry sets
    for (genvar gr = 0; gr < NUM_ELEMS; gr++) begin : g_row
        for (genvar gc = 0; gc < NUM_ELEMS; gc++) begin : g_col
            localparam int unsigned REG_IDX = 2 * gc + gr / 2;
            localparam int unsigned LO      = ELEM_W * (gr % 2);
            assign w_row[gr][gc] = r_cfg[REG_IDX[CFG_IDX_W-1:0]][LO +: ELEM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s0 <= 1'b0;
            r_ctl_a  <= '0;
            r_ctl_b  <= '0;
        end else begin
            r_vld_s0       <= start && !busy;
            r_ctl_a.valid  <= r_vld_s0;
            r_ctl_a.opcode <= r_item_s0.opcode;
            r_ctl_b        <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item_s0 <= i_item;
        end
    end

    for (genvar gl = 0; gl < NUM_ELEMS; gl++) begin : g_lane
        mvt_lane #(
            .ROW        (gl),
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_row  (w_row[gl]),
            .i_item (r_item_s0),
            .i_ctl  (r_ctl_b),
            .o_res  (w_lane[gl])
        );
    end

    mvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl_b),
        .i_lane  (w_lane),
        .o_valid (o_res_valid),
        .o_item  (o_res)
    );

    localparam logic signed [ELEM_W-1:0] RES_MAX =
        ELEM_W'((33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1);
    localparam logic signed [ELEM_W-1:0] RES_MIN = -RES_MAX - ELEM_W'(1);

    // Every accepted item yields a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_res_valid)
        else $error("accepted item produced no result");

    // No result without a matching earlier accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy, 4))
        else $error("result without an accepted item");

    // Result elements stay inside the saturation range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.res_x <= RES_MAX && o_res.res_x >= RES_MIN
                      && o_res.res_y <= RES_MAX && o_res.res_y >= RES_MIN
                      && o_res.res_z <= RES_MAX && o_res.res_z >= RES_MIN
                      && o_res.res_w <= RES_MAX && o_res.res_w >= RES_MIN))
        else $error("result element outside saturation range");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 4x4 matrix-vector unit
// Runs a short directed table under the identity matrix, then batches of
// random vectors under a series of matrix settings. Each result is checked
// against its table entry or a fixed-point datapath model held in the bench.
// ----------------------------------------------------------------------------
module testbench
    import mvt_pkg::*;
();

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int BATCHES      = 14;
    localparam int BATCH_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam longint      SAT_HI    = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint      SAT_LO    = -SAT_HI - 1;

    typedef enum int {
        MAT_IDENTITY,
        MAT_ALL_MAX,
        MAT_ALL_MIN,
        MAT_ZERO,
        MAT_RANDOM,
        MAT_SMALL,
        MAT_MIXED,
        MAT_KINDS
    } t_mat_kind;

    typedef struct packed {
        t_in_item  item;
        logic      known;
        t_out_item result;
    } t_vector_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_res_valid;
    t_out_item            o_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    logic [CFG_W-1:0] matrix_words [NUM_CFG];
    t_out_item        vector_results_due [$];
    t_vector_row      directed_rows [$];
    int               gap_pct;
    int               fail_count  = 0;
    int               cycle_count = 0;

    mat4_vector_transform_unit_top #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point model of the matrix-vector datapath
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] matrix_entry(input int r, input int c);
        logic [CFG_W-1:0] word;
        word = matrix_words[c * 2 + r / 2];
        return (r % 2 == 1) ? word[63:32] : word[31:0];
    endfunction

    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout logic hit);
        if (v > SAT_HI) begin
            hit = 1'b1;
            return 32'(SAT_HI);
        end
        if (v < SAT_LO) begin
            hit = 1'b1;
            return 32'(SAT_LO);
        end
        return v[31:0];
    endfunction

    function automatic t_out_item transform_vector(input t_in_item it);
        logic signed [31:0]  vec [4];
        logic signed [127:0] acc;
        logic [31:0]         lane [4];
        logic                hit;
        t_out_item           res;
        vec[0] = it.elem_x;
        vec[1] = it.elem_y;
        vec[2] = it.elem_z;
        vec[3] = it.elem_w;
        hit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            case (it.opcode)
                OP_XFORM: begin
                    // full-width dot product, then floor shift
                    for (int c = 0; c < 4; c++)
                        acc = acc + matrix_entry(r, c) * vec[c];
                    acc = acc >>> FRAC_BITS;
                end
                OP_ADD: acc = matrix_entry(r, it.col_index) + vec[r];
                OP_SUB: acc = matrix_entry(r, it.col_index) - vec[r];
                default: acc = '0;
            endcase
            lane[r] = saturate(acc, hit);
        end
        res.res_x   = lane[0];
        res.res_y   = lane[1];
        res.res_z   = lane[2];
        res.res_w   = lane[3];
        res.clamped = hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Value generators
    // ------------------------------------------------------------------
    function automatic logic [31:0] extreme_value();
        case ($urandom_range(6))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return Q_ZERO;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return Q_ONE;
            default: return Q_NEG_ONE;
        endcase
    endfunction

    // roughly -8.0 to +8.0 in Q16.16
    function automatic logic [31:0] small_q();
        return int'($urandom_range(32'h10_0000)) - 32'sh8_0000;
    endfunction

    function automatic logic [31:0] random_elem();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return small_q();
            8: return extreme_value();
            default: return int'($urandom_range(512)) - 256;
        endcase
    endfunction

    function automatic logic [31:0] matrix_lane(input t_mat_kind kind);
        case (kind)
            MAT_ALL_MAX: return Q_MAX;
            MAT_ALL_MIN: return Q_MIN;
            MAT_ZERO:    return Q_ZERO;
            MAT_SMALL:   return small_q();
            MAT_MIXED:   return extreme_value();
            default:     return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode    = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
        it.col_index = 2'($urandom_range(3));
        it.elem_x    = random_elem();
        it.elem_y    = random_elem();
        it.elem_z    = random_elem();
        it.elem_w    = random_elem();
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic issue_item(input t_in_item it, input logic known, input t_out_item typed);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        vector_results_due = {vector_results_due, (known ? typed : transform_vector(it))};
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (vector_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_matrix(input t_mat_kind kind);
        logic [CFG_W-1:0] word;
        for (int i = 0; i < NUM_CFG; i++) begin
            if (kind == MAT_IDENTITY)
                word = MAT_RESET[i];
            else
                word = {matrix_lane(kind), matrix_lane(kind)};
            i_cfg_we        <= 1'b1;
            i_cfg_idx       <= CFG_IDX_W'(i);
            i_cfg_data      <= word;
            matrix_words[i]  = word;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic table_row(input logic [1:0] op, input logic [1:0] col,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w,
                             input logic known,
                             input logic [31:0] rx, input logic [31:0] ry,
                             input logic [31:0] rz, input logic [31:0] rw,
                             input logic rc);
        t_vector_row row;
        row.item.opcode     = op;
        row.item.col_index  = col;
        row.item.elem_x     = x;
        row.item.elem_y     = y;
        row.item.elem_z     = z;
        row.item.elem_w     = w;
        row.known           = known;
        row.result.res_x    = rx;
        row.result.res_y    = ry;
        row.result.res_z    = rz;
        row.result.res_w    = rw;
        row.result.clamped  = rc;
        directed_rows = {directed_rows, row};
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic compare_lane(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_vector_results
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (vector_results_due.size() == 0) begin
                $display("%0t: result %h arrived with none expected, got %h",
                         $time, o_res, o_res);
                fail_count++;
            end else begin
                want = vector_results_due.pop_front();
                compare_lane("res_x", want.res_x, o_res.res_x);
                compare_lane("res_y", want.res_y, o_res.res_y);
                compare_lane("res_z", want.res_z, o_res.res_z);
                compare_lane("res_w", want.res_w, o_res.res_w);
                compare_lane("clamped", 32'(want.clamped), 32'(o_res.clamped));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < NUM_CFG; i++)
            matrix_words[i] = MAT_RESET[i];
        gap_pct = 28;

        // identity matrix after reset; known rows are read straight off it
        //        op         col   x          y          z       w          known
        //        res_x      res_y      res_z   res_w      clamped
        table_row(OP_XFORM,  2'd0, Q_ONE,     Q_NEG_ONE, Q_ZERO, Q_MAX,     1'b1,
                  Q_ONE,     Q_NEG_ONE, Q_ZERO, Q_MAX,     1'b0);
        table_row(OP_XFORM,  2'd0, Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b1,
                  Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b0);
        table_row(OP_XFORM,  2'd0, Q_MIN,     Q_MIN,     Q_MIN,  Q_MIN,     1'b1,
                  Q_MIN,     Q_MIN,     Q_MIN,  Q_MIN,     1'b0);
        table_row(OP_XFORM,  2'd3, Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1,
                  Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b0);
        // column index has no effect on a transform
        table_row(OP_XFORM,  2'd3, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 1'b1,
                  32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 1'b0);
        table_row(OP_ADD,    2'd0, Q_MAX,     Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1,
                  Q_MAX,     Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1);
        table_row(OP_SUB,    2'd1, Q_ZERO,    Q_MIN,     Q_ZERO, Q_ZERO,    1'b1,
                  Q_ZERO,    Q_MAX,     Q_ZERO, Q_ZERO,    1'b1);
        table_row(OP_ADD,    2'd2, Q_MIN,     Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1,
                  Q_MIN,     Q_ZERO,    Q_ONE,  Q_ZERO,    1'b0);
        table_row(OP_SUB,    2'd0, Q_MIN,     Q_MIN,     Q_MIN,  Q_MIN,     1'b1,
                  Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b1);
        table_row(OP_ADD,    2'd3, Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b1,
                  Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b1);
        table_row(OP_ADD,    2'd0, Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1,
                  Q_ONE,     Q_ZERO,    Q_ZERO, Q_ZERO,    1'b0);
        table_row(OP_SUB,    2'd2, Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b1,
                  Q_ZERO,    Q_ZERO,    Q_ONE,  Q_ZERO,    1'b0);
        // unused opcode returns all zero
        table_row(OP_UNUSED, 2'd0, Q_ONE,     Q_MAX,     Q_MIN,  Q_NEG_ONE, 1'b1,
                  Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b0);
        table_row(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
        table_row(OP_SUB,    2'd2, Q_MAX,     Q_MAX,     Q_MAX,  Q_MAX,     1'b0,
                  Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b0);
        table_row(OP_SUB,    2'd3, Q_ZERO,    Q_ZERO,    Q_ZERO, Q_MAX,     1'b0,
                  Q_ZERO,    Q_ZERO,    Q_ZERO, Q_ZERO,    1'b0);
        table_row(OP_ADD,    2'd1, Q_NEG_ONE, Q_NEG_ONE, 32'h0000_8000, 32'hFFFF_8000,
                  1'b0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
        table_row(OP_XFORM,  2'd2, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_FFFF,
                  32'h8000_0001, 1'b0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            issue_item(directed_rows[k].item, directed_rows[k].known,
                       directed_rows[k].result);
        drain_results();

        for (int b = 0; b < BATCHES; b++) begin
            gap_pct = (b < 5) ? 28 : (b < 10) ? 85 : 0;
            write_matrix(t_mat_kind'(b % MAT_KINDS));
            repeat (BATCH_ITEMS)
                issue_item(random_item(), 1'b0, '0);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/mvt_pkg.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/mat4_vector_transform_unit_top.sv
test/testbench.sv
